### hdl/compacting_fixed_list_macros.svh
// Assertion macros shared by the list block.
`ifndef COMPACTING_FIXED_LIST_MACROS_SVH
`define COMPACTING_FIXED_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list assertion failed");

// Next-cycle implication, disabled during reset.
`define CFL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list assertion failed");

`endif

### hdl/cfl_pkg.sv
// Shared types and constants of the compacting list block.
package cfl_pkg;

    localparam int MODE_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int RDATA_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_INDEX = 2'd0,
        RD_NEXT  = 2'd1,
        RD_FIRST = 2'd2,
        RD_LAST  = 2'd3
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_CAP,
        S_SH_RD,
        S_SH_WR,
        S_FX0,
        S_FX1,
        S_FX2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_append;
        logic    wr_shift;
        logic    count_inc;
        logic    count_dec;
        logic    ptr_load;
        logic    ptr_inc;
        logic    set_status;
        t_status status;
        logic    cap_rd;
        logic    cap_first;
        logic    cap_last;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  full;
        logic  idx_ok;
        logic  more;
    } t_stat;

endpackage

### hdl/cfl_ctrl.sv
// Sequencer for the compacting list: issues datapath commands per request.
module cfl_ctrl
    import cfl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.mode)
                    MODE_REMOVE: begin
                        if (!i_stat.empty && i_stat.idx_ok) n_state = S_SH_RD;
                        else                                n_state = S_FX0;
                    end
                    MODE_READ: begin
                        if (i_stat.idx_ok) n_state = S_RD_CAP;
                        else               n_state = S_FX0;
                    end
                    default: n_state = S_FX0;
                endcase
            end
            S_RD_CAP: n_state = S_FX0;
            S_SH_RD: begin
                if (i_stat.more) n_state = S_SH_WR;
                else             n_state = S_FX0;
            end
            S_SH_WR: n_state = S_SH_RD;
            S_FX0:   n_state = S_FX1;
            S_FX1:   n_state = S_FX2;
            S_FX2:   n_state = S_DONE;
            S_DONE: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            S_DECODE: begin
                case (i_stat.mode)
                    MODE_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.wr_append = 1'b1;
                            o_cmd.count_inc = 1'b1;
                        end
                    end
                    MODE_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else if (!i_stat.idx_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BADIDX;
                        end else begin
                            o_cmd.ptr_load = 1'b1;
                        end
                    end
                    MODE_READ: begin
                        if (!i_stat.idx_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BADIDX;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_INDEX;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_CAP: begin
                o_cmd.cap_rd = 1'b1;
            end
            S_SH_RD: begin
                if (i_stat.more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end else begin
                    o_cmd.count_dec = 1'b1;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
            end
            S_FX0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_FIRST;
            end
            S_FX1: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = RD_LAST;
            end
            S_FX2: begin
                o_cmd.cap_last = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = w_slot_free;
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/cfl_datapath.sv
// Entry memory, count, shift pointer and result register of the list.
module cfl_datapath
    import cfl_pkg::*;
#(
    parameter int LIST_CAPACITY = 16,
    parameter int DATA_WIDTH    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [INDEX_W-1:0]  i_index,
    output logic [STATUS_W-1:0] o_status,
    output logic [RDATA_W-1:0]  o_read_data,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic                o_is_empty,
    output logic [RDATA_W-1:0]  o_first_data,
    output logic [RDATA_W-1:0]  o_last_data
);

    localparam int AW = $clog2(LIST_CAPACITY);
    localparam int CW = $clog2(LIST_CAPACITY + 1);

    logic [DATA_WIDTH-1:0] r_mem [LIST_CAPACITY];

    t_mode                 r_mode;
    logic [DATA_WIDTH-1:0] r_value;
    logic [INDEX_W-1:0]    r_index;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_ptr;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [DATA_WIDTH-1:0] r_first;
    logic [DATA_WIDTH-1:0] r_last;
    t_status               r_status;

    logic [STATUS_W-1:0]   r_out_status;
    logic [RDATA_W-1:0]    r_out_rd;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_empty;
    logic [RDATA_W-1:0]    r_out_first;
    logic [RDATA_W-1:0]    r_out_last;

    logic [63:0]           w_value_ext;
    logic [31:0]           w_index_ext;
    logic [31:0]           w_count_ext;
    logic [31:0]           w_ptr_next;
    logic [AW-1:0]         w_rd_addr;
    logic [63:0]           w_rd_ext;
    logic [63:0]           w_first_ext;
    logic [63:0]           w_last_ext;

    assign w_value_ext = 64'(i_value);
    assign w_index_ext = 32'(r_index);
    assign w_count_ext = 32'(r_count);
    assign w_ptr_next  = 32'(r_ptr) + 32'd1;
    assign w_rd_ext    = 64'(r_rd);
    assign w_first_ext = 64'(r_first);
    assign w_last_ext  = 64'(r_last);

    assign o_stat.mode   = r_mode;
    assign o_stat.empty  = (r_count == '0);
    assign o_stat.full   = (r_count == CW'(LIST_CAPACITY));
    assign o_stat.idx_ok = (w_index_ext < w_count_ext);
    assign o_stat.more   = (w_ptr_next < w_count_ext);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_INDEX: w_rd_addr = w_index_ext[AW-1:0];
            RD_NEXT:  w_rd_addr = w_ptr_next[AW-1:0];
            RD_FIRST: w_rd_addr = '0;
            RD_LAST:  w_rd_addr = AW'(r_count - 1'b1);
            default:  w_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_append) begin
            r_mem[AW'(r_count)] <= r_value;
        end else if (i_cmd.wr_shift) begin
            r_mem[r_ptr] <= r_q;
        end
        if (i_cmd.rd_en) begin
            r_q <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= t_mode'(i_mode);
            r_value  <= w_value_ext[DATA_WIDTH-1:0];
            r_index  <= i_index;
            r_rd     <= '0;
            r_status <= ST_OK;
        end else begin
            if (i_cmd.set_status) r_status <= i_cmd.status;
            if (i_cmd.cap_rd)     r_rd     <= r_q;
        end
        if (i_cmd.ptr_load) begin
            r_ptr <= w_index_ext[AW-1:0];
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= w_ptr_next[AW-1:0];
        end
        if (i_cmd.cap_first) r_first <= r_q;
        if (i_cmd.cap_last)  r_last  <= r_q;
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_rd     <= w_rd_ext[RDATA_W-1:0];
            r_out_count  <= w_count_ext[COUNT_W-1:0];
            r_out_empty  <= o_stat.empty;
            r_out_first  <= o_stat.empty ? '0 : w_first_ext[RDATA_W-1:0];
            r_out_last   <= o_stat.empty ? '0 : w_last_ext[RDATA_W-1:0];
        end
    end

    assign o_status      = r_out_status;
    assign o_read_data   = r_out_rd;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_first_data  = r_out_first;
    assign o_last_data   = r_out_last;

endmodule

### hdl/compacting_fixed_list.sv
// Top level of the compacting fixed-capacity list with stream ports.
//
//  channel   dir   handshake                 payload
//  request   in    i_s_tvalid / o_s_tready   i_s_tdata (mode, value, index)
//  result    out   o_m_tvalid / i_m_tready   o_m_tdata (status .. last_data)
//
// Append, no-op and any request that fails its check go from accept through decode, the
// FX0, FX1 and FX2 states (first and last capture) and done; a good read adds a capture state.
// A good remove also moves each later entry down through the single memory port in one read and one write.
// Synchronous active-low reset empties the list; memory contents are not cleared.
// A stalled result holds the sequencer in its final state until the output frees.
`include "compacting_fixed_list_macros.svh"

module compacting_fixed_list
    import cfl_pkg::*;
#(
    parameter int LIST_CAPACITY = 16,
    parameter int DATA_WIDTH    = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // mode[1:0], value[33:2], index[37:34], zero pad[39:38]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status[1:0], read_data[33:2], entry_count[38:34], is_empty[39],
    // first_data[71:40], last_data[103:72]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_cmd                s_cmd;
    t_stat               s_stat;
    logic [STATUS_W-1:0] w_status;
    logic [RDATA_W-1:0]  w_read_data;
    logic [COUNT_W-1:0]  w_entry_count;
    logic                w_is_empty;
    logic [RDATA_W-1:0]  w_first_data;
    logic [RDATA_W-1:0]  w_last_data;

    cfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd)
    );

    cfl_datapath #(
        .LIST_CAPACITY (LIST_CAPACITY),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_stat        (s_stat),
        .i_mode        (i_s_tdata[1:0]),
        .i_value       (i_s_tdata[33:2]),
        .i_index       (i_s_tdata[37:34]),
        .o_status      (w_status),
        .o_read_data   (w_read_data),
        .o_entry_count (w_entry_count),
        .o_is_empty    (w_is_empty),
        .o_first_data  (w_first_data),
        .o_last_data   (w_last_data)
    );

    assign o_m_tdata = {w_last_data, w_first_data, w_is_empty, w_entry_count,
                        w_read_data, w_status};

    `CFL_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `CFL_ASSERT_IMP(a_load_slot_free, i_clk, i_rst_n, s_cmd.load_out, !o_m_tvalid || i_m_tready)
    `CFL_ASSERT_IMP(a_shift_in_range, i_clk, i_rst_n, s_cmd.wr_shift, s_stat.more)
    `CFL_ASSERT_IMP(a_append_not_full, i_clk, i_rst_n, s_cmd.wr_append, !s_stat.full)

endmodule
